// ===== rtl/core/epoch_note_collector_core_defines.svh =====
// Assertion helpers for the collector core.
`ifndef EPOCH_NOTE_COLLECTOR_CORE_DEFINES_SVH
`define EPOCH_NOTE_COLLECTOR_CORE_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define ENC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define ENC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/enc_pkg.sv =====
package enc_pkg;

    localparam int RING_SLOTS  = 16;
    localparam int RING_PTR_W  = $clog2(RING_SLOTS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int EPOCH_W = 64;
    localparam int COUNT_W = 32;
    localparam int PROG_W  = 32;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 4;

    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 168;

    localparam logic [KIND_W-1:0] KIND_BEGIN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUBLISH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COLLECT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RSVD    = 2'd3;

    typedef enum logic [1:0] {
        OP_BEGIN,
        OP_PUBLISH,
        OP_COLLECT,
        OP_INVALID
    } cmd_op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK           = 4'd0,
        ST_QUEUED       = 4'd1,
        ST_QUEUED_ARMED = 4'd2,
        ST_BAD_ARG      = 4'd3,
        ST_FULL         = 4'd4,
        ST_MISMATCH     = 4'd5,
        ST_INCOMPLETE   = 4'd6,
        ST_PENDING      = 4'd7,
        ST_NOTE         = 4'd8,
        ST_NOTHING      = 4'd9
    } status_t;

    typedef struct packed {
        cmd_op_t             op;
        logic                epoch_zero;
        logic                prog_zero;
        logic                with_data;
        logic [EPOCH_W-1:0]  epoch;
        logic [COUNT_W-1:0]  expected;
        logic [PROG_W-1:0]   prog;
    } cmd_t;

    typedef struct packed {
        logic draining;
        logic ring_empty;
    } back_stat_t;

endpackage

// ===== rtl/core/enc_front.sv =====
module enc_front
    import enc_pkg::*;
(
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,   // epoch_id, answers_expected, program_ident,
                                             // carries_data
    input  logic [KIND_W-1:0]     s_tuser,   // kind
    input  logic                  q_full,
    output logic                  q_push,
    output cmd_t                  q_cmd
);

    logic [EPOCH_W-1:0] epoch;
    logic [COUNT_W-1:0] expected;
    logic [PROG_W-1:0]  prog;

    assign epoch    = s_tdata[63:0];
    assign expected = s_tdata[95:64];
    assign prog     = s_tdata[127:96];

    always_comb begin
        unique case (s_tuser)
            KIND_BEGIN:   q_cmd.op = OP_BEGIN;
            KIND_PUBLISH: q_cmd.op = OP_PUBLISH;
            KIND_COLLECT: q_cmd.op = OP_COLLECT;
            KIND_RSVD:    q_cmd.op = OP_INVALID;
            default:      q_cmd.op = OP_INVALID;
        endcase
        q_cmd.epoch_zero = (epoch == '0);
        q_cmd.prog_zero  = (prog == '0);
        q_cmd.with_data  = s_tdata[128];
        q_cmd.epoch      = epoch;
        q_cmd.expected   = expected;
        q_cmd.prog       = prog;
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

// ===== rtl/core/enc_queue.sv =====
module enc_queue
    import enc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    function automatic logic [QUEUE_PTR_W-1:0] q_inc(input logic [QUEUE_PTR_W-1:0] p);
        return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
    endfunction

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? q_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? q_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/enc_back.sv =====
module enc_back
    import enc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  cmd_t                   q_cmd,
    output logic                   q_pop,
    output back_stat_t             stat,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // note_program, note_epoch, answered_count,
                                             // data_count, collect_armed, epoch_complete
    output logic [STAT_W-1:0]      m_tuser,  // status
    output logic                   m_tlast
);

    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } state_t;

    state_t state_reg, state_next;

    logic [PROG_W-1:0]  ring_prog_mem  [RING_SLOTS];
    logic [EPOCH_W-1:0] ring_epoch_mem [RING_SLOTS];
    logic [PROG_W-1:0]  rd_prog_reg;
    logic [EPOCH_W-1:0] rd_epoch_reg;

    logic [RING_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RING_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [EPOCH_W-1:0]    cur_epoch_reg, cur_epoch_next;
    logic [COUNT_W-1:0]    expected_reg, expected_next;
    logic [COUNT_W-1:0]    answered_reg, answered_next;
    logic [COUNT_W-1:0]    data_total_reg, data_total_next;
    logic                  data_mode_reg, data_mode_next;
    logic                  pending_reg, pending_next;

    logic                  m_valid_reg, m_valid_next;
    status_t               m_status_reg, m_status_next;
    logic [PROG_W-1:0]     m_prog_reg, m_prog_next;
    logic [EPOCH_W-1:0]    m_epoch_reg, m_epoch_next;
    logic [COUNT_W-1:0]    m_answered_reg, m_answered_next;
    logic [COUNT_W-1:0]    m_data_reg, m_data_next;
    logic                  m_armed_reg, m_armed_next;
    logic                  m_complete_reg, m_complete_next;
    logic                  m_last_reg, m_last_next;

    logic                  out_free, take, emit, mem_we, armed;
    logic                  complete_cur;
    logic [RING_PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;
    status_t               emit_status;
    logic [PROG_W-1:0]     emit_prog;
    logic [EPOCH_W-1:0]    emit_epoch;
    logic                  emit_last;

    function automatic logic [RING_PTR_W-1:0] ring_inc(input logic [RING_PTR_W-1:0] p);
        return (p == RING_PTR_W'(RING_SLOTS - 1)) ? '0 : p + RING_PTR_W'(1);
    endfunction

    assign out_free     = !m_valid_reg || m_tready;
    assign take         = (state_reg == S_IDLE) && q_valid && out_free;
    assign q_pop        = take;
    assign wr_ptr_inc   = ring_inc(wr_ptr_reg);
    assign rd_ptr_inc   = ring_inc(rd_ptr_reg);
    assign complete_cur = (expected_reg == '0) || (answered_reg >= expected_reg);

    assign stat.draining   = (state_reg == S_DRAIN);
    assign stat.ring_empty = (rd_ptr_reg == wr_ptr_reg);

    always_comb begin
        state_next      = state_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        cur_epoch_next  = cur_epoch_reg;
        expected_next   = expected_reg;
        answered_next   = answered_reg;
        data_total_next = data_total_reg;
        data_mode_next  = data_mode_reg;
        pending_next    = pending_reg;
        emit            = 1'b0;
        mem_we          = 1'b0;
        armed           = 1'b0;
        emit_status     = ST_OK;
        emit_prog       = '0;
        emit_epoch      = '0;
        emit_last       = 1'b1;

        if (take) begin
            emit = 1'b1;
            unique case (q_cmd.op)
                OP_BEGIN: begin
                    priority if (q_cmd.epoch_zero) begin
                        emit_status = ST_BAD_ARG;
                    end else if (!complete_cur) begin
                        emit_status = ST_INCOMPLETE;
                    end else if (pending_reg) begin
                        emit_status = ST_PENDING;
                    end else begin
                        rd_ptr_next     = '0;
                        wr_ptr_next     = '0;
                        data_mode_next  = 1'b0;
                        cur_epoch_next  = q_cmd.epoch;
                        expected_next   = q_cmd.expected;
                        answered_next   = '0;
                        data_total_next = '0;
                        emit_status     = ST_OK;
                    end
                end
                OP_PUBLISH: begin
                    priority if (q_cmd.prog_zero) begin
                        emit_status = ST_BAD_ARG;
                    end else if (q_cmd.epoch != cur_epoch_reg) begin
                        emit_status = ST_MISMATCH;
                    end else if (q_cmd.with_data) begin
                        if (!data_mode_reg) begin
                            data_mode_next = 1'b1;
                            if (!pending_reg) begin
                                pending_next = 1'b1;
                                armed        = 1'b1;
                            end
                        end
                        if (wr_ptr_inc == rd_ptr_reg) begin
                            emit_status = ST_FULL;
                        end else begin
                            mem_we          = 1'b1;
                            wr_ptr_next     = wr_ptr_inc;
                            data_total_next = data_total_reg + COUNT_W'(1);
                            answered_next   = answered_reg + COUNT_W'(1);
                            emit_status     = armed ? ST_QUEUED_ARMED : ST_QUEUED;
                        end
                    end else begin
                        answered_next = answered_reg + COUNT_W'(1);
                        emit_status   = ST_OK;
                    end
                end
                OP_COLLECT: begin
                    priority if (!pending_reg) begin
                        emit_status = ST_NOTHING;
                    end else if (!complete_cur) begin
                        emit_status = ST_INCOMPLETE;
                    end else begin
                        pending_next   = 1'b0;
                        data_mode_next = 1'b0;
                        if (rd_ptr_reg == wr_ptr_reg) begin
                            emit_status = ST_OK;
                        end else begin
                            emit       = 1'b0;
                            state_next = S_DRAIN;
                        end
                    end
                end
                default: begin
                    emit_status = ST_BAD_ARG;
                end
            endcase
        end else if (state_reg == S_DRAIN && out_free) begin
            emit        = 1'b1;
            emit_status = ST_NOTE;
            emit_prog   = rd_prog_reg;
            emit_epoch  = rd_epoch_reg;
            emit_last   = (rd_ptr_inc == wr_ptr_reg);
            rd_ptr_next = rd_ptr_inc;
            if (emit_last) begin
                state_next = S_IDLE;
            end
        end
    end

    always_comb begin
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_prog_next     = m_prog_reg;
        m_epoch_next    = m_epoch_reg;
        m_answered_next = m_answered_reg;
        m_data_next     = m_data_reg;
        m_armed_next    = m_armed_reg;
        m_complete_next = m_complete_reg;
        m_last_next     = m_last_reg;
        if (emit) begin
            m_valid_next    = 1'b1;
            m_status_next   = emit_status;
            m_prog_next     = emit_prog;
            m_epoch_next    = emit_epoch;
            m_answered_next = answered_next;
            m_data_next     = data_total_next;
            m_armed_next    = pending_next;
            m_complete_next = (expected_next == '0) || (answered_next >= expected_next);
            m_last_next     = emit_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            cur_epoch_reg  <= '0;
            expected_reg   <= '0;
            answered_reg   <= '0;
            data_total_reg <= '0;
            data_mode_reg  <= 1'b0;
            pending_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            cur_epoch_reg  <= cur_epoch_next;
            expected_reg   <= expected_next;
            answered_reg   <= answered_next;
            data_total_reg <= data_total_next;
            data_mode_reg  <= data_mode_next;
            pending_reg    <= pending_next;
            m_valid_reg    <= m_valid_next;
        end
        m_status_reg   <= m_status_next;
        m_prog_reg     <= m_prog_next;
        m_epoch_reg    <= m_epoch_next;
        m_answered_reg <= m_answered_next;
        m_data_reg     <= m_data_next;
        m_armed_reg    <= m_armed_next;
        m_complete_reg <= m_complete_next;
        m_last_reg     <= m_last_next;
    end

    // ring store; read address follows the next read pointer so data lines up
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_prog_mem[wr_ptr_reg]  <= q_cmd.prog;
            ring_epoch_mem[wr_ptr_reg] <= q_cmd.epoch;
        end
        rd_prog_reg  <= ring_prog_mem[rd_ptr_next];
        rd_epoch_reg <= ring_epoch_mem[rd_ptr_next];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {6'b0, m_complete_reg, m_armed_reg, m_data_reg, m_answered_reg,
                       m_epoch_reg, m_prog_reg};

endmodule

// ===== rtl/core/epoch_note_collector_core.sv =====
// Epoch note collector. Input beats carry a request kind on s_tuser (begin epoch,
// publish answer, collect notes). A front stage decodes each beat into a command and
// parks it in a two-entry queue, so the input keeps accepting until the queue is full
// while the back end stalls on m_tready. The back end owns the epoch state and a ring of
// RING_SLOTS note slots (one always kept empty). Begin and publish each give one result
// beat. A collect that drains notes first enters the drain state while the ring read is
// set up, then gives one beat per note as m_tready allows, with m_tlast on the final note;
// every other request gives one beat with m_tlast set. Each result beat reports the status
// code on m_tuser along with the answer and data counters, the armed flag and the epoch
// complete flag as they stand after the request. Counters wrap at 32 bits.
`include "epoch_note_collector_core_defines.svh"

module epoch_note_collector_core
    import enc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // epoch_id[63:0], answers_expected[95:64],
                                              // program_ident[127:96], carries_data[128]
    input  logic [KIND_W-1:0]      s_tuser,   // kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // note_program[31:0], note_epoch[95:32],
                                              // answered_count[127:96], data_count[159:128],
                                              // collect_armed[160], epoch_complete[161]
    output logic [STAT_W-1:0]      m_tuser,   // status
    output logic                   m_tlast
);

    logic       q_full, q_push, q_pop, q_valid;
    cmd_t       push_cmd, head_cmd;
    back_stat_t back_stat;

    enc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    enc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    enc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .stat     (back_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `ENC_ASSERT_NOW(a_no_pop_in_drain, aclk, aresetn, back_stat.draining, !q_pop, "command popped during drain")
    `ENC_ASSERT_NOW(a_note_flags, aclk, aresetn, m_tvalid && (m_tuser == ST_NOTE), !m_tdata[160] && m_tdata[161], "note beat with armed or incomplete epoch")
    `ENC_ASSERT_NOW(a_single_beat, aclk, aresetn, m_tvalid && (m_tuser != ST_NOTE), m_tlast && (m_tdata[95:0] == '0), "non-note beat not single or carries a note")
    `ENC_ASSERT_NEXT(a_drain_empty_exit, aclk, aresetn, back_stat.draining && back_stat.ring_empty, 1'b0, "drain running on an empty ring")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
    import enc_pkg::*;
();

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [EPOCH_W-1:0] epoch;
        logic [COUNT_W-1:0] expected;
        logic [PROG_W-1:0]  prog;
        logic               with_data;
        bit                 hold;
    } request_t;

    typedef struct {
        status_t            status;
        logic [PROG_W-1:0]  prog;
        logic [EPOCH_W-1:0] epoch;
        logic [COUNT_W-1:0] answered;
        logic [COUNT_W-1:0] stored;
        logic               armed;
        logic               done;
        logic               last;
    } reply_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]      m_tuser;
    logic                   m_tlast;

    epoch_note_collector_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    request_t request_q[$];
    reply_t   reply_q[$];
    request_t cur_req;
    int       replies_due = 0;
    int       replies_got = 0;
    int       req_taken = 0;
    int       faults = 0;
    int       cyc = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    logic     quiet;

    assign quiet = (cyc >= 300) && (cyc < 600);

    always @(posedge aclk) begin
        cyc <= cyc + 1;
    end

    // collector state mirror
    logic [PROG_W-1:0]  ring_prog[RING_SLOTS];
    logic [EPOCH_W-1:0] ring_ep[RING_SLOTS];
    int                 rd_slot = 0;
    int                 wr_slot = 0;
    logic [EPOCH_W-1:0] open_epoch = '0;
    logic [COUNT_W-1:0] need_total = '0;
    logic [COUNT_W-1:0] ans_total = '0;
    logic [COUNT_W-1:0] data_total = '0;
    logic               data_phase = 1'b0;
    logic               pend_flag = 1'b0;

    function automatic logic epoch_done();
        return (need_total == '0) || (ans_total >= need_total);
    endfunction

    function automatic void push_reply(status_t st, logic [PROG_W-1:0] pg,
                                       logic [EPOCH_W-1:0] ep, logic lst);
        reply_t rp;
        rp.status   = st;
        rp.prog     = pg;
        rp.epoch    = ep;
        rp.answered = ans_total;
        rp.stored   = data_total;
        rp.armed    = pend_flag;
        rp.done     = epoch_done();
        rp.last     = lst;
        reply_q.push_back(rp);
    endfunction

    function automatic int model_request(request_t rq);
        status_t            st;
        logic               armed_now;
        int                 nxt;
        int                 cnt;
        logic [PROG_W-1:0]  pg[RING_SLOTS];
        logic [EPOCH_W-1:0] ep[RING_SLOTS];
        armed_now = 1'b0;
        cnt = 0;
        case (rq.kind)
            KIND_BEGIN: begin
                if (rq.epoch == '0) begin
                    st = ST_BAD_ARG;
                end else if (!epoch_done()) begin
                    st = ST_INCOMPLETE;
                end else if (pend_flag) begin
                    st = ST_PENDING;
                end else begin
                    rd_slot    = 0;
                    wr_slot    = 0;
                    data_phase = 1'b0;
                    open_epoch = rq.epoch;
                    need_total = rq.expected;
                    ans_total  = '0;
                    data_total = '0;
                    st = ST_OK;
                end
                push_reply(st, '0, '0, 1'b1);
                return 1;
            end
            KIND_PUBLISH: begin
                if (rq.prog == '0) begin
                    st = ST_BAD_ARG;
                end else if (rq.epoch != open_epoch) begin
                    st = ST_MISMATCH;
                end else if (!rq.with_data) begin
                    ans_total = ans_total + 1'b1;
                    st = ST_OK;
                end else begin
                    if (!data_phase) begin
                        data_phase = 1'b1;
                        if (!pend_flag) begin
                            pend_flag = 1'b1;
                            armed_now = 1'b1;
                        end
                    end
                    nxt = (wr_slot + 1) % RING_SLOTS;
                    if (nxt == rd_slot) begin
                        st = ST_FULL;
                    end else begin
                        ring_prog[wr_slot] = rq.prog;
                        ring_ep[wr_slot]   = rq.epoch;
                        wr_slot    = nxt;
                        data_total = data_total + 1'b1;
                        ans_total  = ans_total + 1'b1;
                        st = armed_now ? ST_QUEUED_ARMED : ST_QUEUED;
                    end
                end
                push_reply(st, '0, '0, 1'b1);
                return 1;
            end
            KIND_COLLECT: begin
                if (!pend_flag) begin
                    push_reply(ST_NOTHING, '0, '0, 1'b1);
                    return 1;
                end
                if (!epoch_done()) begin
                    push_reply(ST_INCOMPLETE, '0, '0, 1'b1);
                    return 1;
                end
                pend_flag = 1'b0;
                while (rd_slot != wr_slot) begin
                    pg[cnt] = ring_prog[rd_slot];
                    ep[cnt] = ring_ep[rd_slot];
                    cnt++;
                    rd_slot = (rd_slot + 1) % RING_SLOTS;
                end
                data_phase = 1'b0;
                if (cnt == 0) begin
                    push_reply(ST_OK, '0, '0, 1'b1);
                    return 1;
                end
                for (int i = 0; i < cnt; i++)
                    push_reply(ST_NOTE, pg[i], ep[i], i == cnt - 1);
                return cnt;
            end
            default: begin
                push_reply(ST_BAD_ARG, '0, '0, 1'b1);
                return 1;
            end
        endcase
    endfunction

    always @(posedge aclk) begin : driver
        bit taking;
        int n;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            taking = s_tvalid && s_tready;
            if (taking) begin
                n = model_request(cur_req);
                replies_due <= replies_due + n;
                req_taken <= req_taken + 1;
            end
            if (taking || !s_tvalid) begin
                if (request_q.size() > 0
                        && !(request_q[0].hold && (taking || replies_due != replies_got))
                        && (quiet || $urandom_range(99) >= 37)) begin
                    cur_req = request_q.pop_front();
                    s_tdata  <= {7'd0, cur_req.with_data, cur_req.prog,
                                 cur_req.expected, cur_req.epoch};
                    s_tuser  <= cur_req.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string nm, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, nm, want, got);
            faults++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        reply_t rp;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                replies_got <= replies_got + 1;
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected beat, status expected none actual %0d",
                             $time, m_tuser);
                    faults++;
                end else begin
                    rp = reply_q.pop_front();
                    check_field("status", rp.status, m_tuser);
                    check_field("note_program", rp.prog, m_tdata[31:0]);
                    check_field("note_epoch", rp.epoch, m_tdata[95:32]);
                    check_field("answered_count", rp.answered, m_tdata[127:96]);
                    check_field("data_count", rp.stored, m_tdata[159:128]);
                    check_field("collect_armed", rp.armed, m_tdata[160]);
                    check_field("epoch_complete", rp.done, m_tdata[161]);
                    check_field("last", rp.last, m_tlast);
                end
            end
            // long back-pressure once traffic is flowing
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if (!hold_done && req_taken >= 120) begin
                hold_done <= 1'b1;
                hold_left <= 100;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet || ($urandom_range(99) >= 37);
            end
        end
    end

    // stimulus planning: tracks just enough to keep epochs well formed
    logic [EPOCH_W-1:0] plan_ep;
    logic [COUNT_W-1:0] plan_need;
    logic [COUNT_W-1:0] plan_ans;
    int                 plan_notes;
    bit                 plan_armed;

    function automatic logic [31:0] nz32();
        logic [31:0] v;
        do v = $urandom; while (v == '0);
        return v;
    endfunction

    function automatic logic [63:0] nz64();
        logic [63:0] v;
        do v = {$urandom, $urandom}; while (v == '0);
        return v;
    endfunction

    task automatic queue_req(logic [KIND_W-1:0] k, logic [EPOCH_W-1:0] ep,
                             logic [COUNT_W-1:0] ex, logic [PROG_W-1:0] pg,
                             logic dt, bit hold);
        request_t rq;
        rq.kind = k;
        rq.epoch = ep;
        rq.expected = ex;
        rq.prog = pg;
        rq.with_data = dt;
        rq.hold = hold;
        request_q.push_back(rq);
    endtask

    function automatic bit plan_done();
        return (plan_need == '0) || (plan_ans >= plan_need);
    endfunction

    task automatic queue_answer(bit dt);
        queue_req(KIND_PUBLISH, plan_ep, $urandom, nz32(), dt, 1'b0);
        if (dt) begin
            plan_armed = 1'b1;
            if (plan_notes < RING_SLOTS - 1) begin
                plan_notes++;
                plan_ans++;
            end
        end else begin
            plan_ans++;
        end
    endtask

    task automatic queue_collect();
        queue_req(KIND_COLLECT, {$urandom, $urandom}, $urandom, $urandom,
                  $urandom_range(1), 1'b0);
        if (plan_armed && plan_done()) begin
            plan_armed = 1'b0;
            plan_notes = 0;
        end
    endtask

    task automatic queue_noise();
        case ($urandom_range(5))
            0: queue_req(KIND_PUBLISH, plan_ep ^ nz64(), $urandom, $urandom,
                         $urandom_range(1), 1'b0);
            1: queue_req(KIND_PUBLISH, plan_ep, $urandom, '0, $urandom_range(1), 1'b0);
            2: queue_req(KIND_BEGIN, '0, $urandom, $urandom, $urandom_range(1), 1'b0);
            3: queue_req(KIND_RSVD, {$urandom, $urandom}, $urandom, $urandom,
                         $urandom_range(1), 1'b0);
            4: begin
                if (!plan_done() || plan_armed)
                    queue_req(KIND_BEGIN, nz64(), $urandom, $urandom,
                              $urandom_range(1), 1'b0);
                else
                    queue_req(KIND_BEGIN, '0, $urandom, $urandom, 1'b0, 1'b0);
            end
            default: begin
                if (!plan_done())
                    queue_collect();
                else
                    queue_req(KIND_RSVD, '0, '0, '0, 1'b0, 1'b0);
            end
        endcase
    endtask

    task automatic run_epoch(logic [COUNT_W-1:0] need, int data_pct, bit hold);
        int extra;
        plan_ep    = nz64();
        plan_need  = need;
        plan_ans   = '0;
        plan_notes = 0;
        plan_armed = 1'b0;
        queue_req(KIND_BEGIN, plan_ep, need, $urandom, $urandom_range(1), hold);
        extra = $urandom_range(2);
        while (!plan_done() || extra > 0) begin
            if (plan_done())
                extra--;
            if ($urandom_range(99) < 15)
                queue_noise();
            queue_answer($urandom_range(99) < data_pct);
        end
        if (plan_armed && $urandom_range(3) == 0)
            queue_req(KIND_BEGIN, nz64(), $urandom, $urandom, 1'b0, 1'b0);
        queue_collect();
        if ($urandom_range(2) == 0) begin
            repeat ($urandom_range(1, 4)) queue_answer(1'b1);
            queue_collect();
        end
    endtask

    initial begin
        logic [63:0] ones;
        ones = '1;

        queue_req(KIND_COLLECT, '0, '0, '0, 1'b0, 1'b0);
        queue_req(KIND_RSVD, ones, '1, '1, 1'b1, 1'b0);
        queue_req(KIND_BEGIN, '0, '1, nz32(), 1'b0, 1'b0);
        queue_req(KIND_PUBLISH, '0, '0, '0, 1'b1, 1'b0);
        queue_req(KIND_PUBLISH, '0, '0, '1, 1'b0, 1'b0);
        queue_req(KIND_BEGIN, ones, 32'd16, '0, 1'b0, 1'b0);
        queue_req(KIND_PUBLISH, '0, '0, nz32(), 1'b1, 1'b0);
        queue_req(KIND_BEGIN, 64'd1, 32'd3, '0, 1'b0, 1'b0);
        queue_req(KIND_COLLECT, '0, '0, '0, 1'b0, 1'b0);
        queue_req(KIND_PUBLISH, ones, '0, '1, 1'b1, 1'b0);
        repeat (RING_SLOTS - 2) queue_req(KIND_PUBLISH, ones, '0, nz32(), 1'b1, 1'b0);
        // ring now full
        queue_req(KIND_PUBLISH, ones, '0, nz32(), 1'b1, 1'b0);
        queue_req(KIND_COLLECT, '0, '0, '0, 1'b0, 1'b0);
        queue_req(KIND_PUBLISH, ones, '0, nz32(), 1'b0, 1'b0);
        queue_req(KIND_BEGIN, 64'd2, 32'd1, '0, 1'b0, 1'b0);
        queue_req(KIND_COLLECT, '0, '0, '0, 1'b0, 1'b0);

        plan_armed = 1'b0;
        run_epoch(32'd0, 50, 1'b1);
        while (request_q.size() < 245) begin
            if ($urandom_range(8) == 0)
                run_epoch($urandom_range(16, 20), 85, $urandom_range(4) == 0);
            else
                run_epoch($urandom_range(0, 10), 60, $urandom_range(4) == 0);
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (request_q.size() != 0 || s_tvalid || replies_due != replies_got)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (reply_q.size() != 0) begin
            $display("%0t: %0d beats expected, actual 0 received", $time, reply_q.size());
            faults++;
        end
        if (faults == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
